FILE: rtl/stable_sorted_priority_queue_defines.svh
// assertion macros for the sorted priority queue
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq same-cycle check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq next-cycle check failed");

`endif

FILE: rtl/spq_pkg.sv
// shared types, sizes and codes of the sorted priority queue
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  age;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry entry;
    } t_cmd;

    typedef struct packed {
        logic   valid;
        logic   lt;
        t_entry entry;
    } t_link;

endpackage

FILE: rtl/stable_sorted_priority_queue.sv
// top level: bounded stable priority queue built as a chain of sorting cells
//
//  channel   | handshake            | fields
//  ----------+----------------------+--------------------------------------------
//  command   | start / busy         | i_kind i_payload_tag i_age i_priority_req
//  result    | o_strobe (no stall)  | o_status o_out_valid o_out_tag o_out_age
//            |                      | o_out_priority o_occupancy
//
//  one word accepted per cycle while busy is low; its result strobes in the following cycle
//  every cell compares against the broadcast word and registers its shift
//  busy is high during reset and in the first cycle after reset
//  reset empties the queue; the receiver cannot stall the result
module stable_sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_payload_tag,
    input  logic [7:0]  i_age,
    input  logic [7:0]  i_priority_req,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_out_valid,
    output logic [31:0] o_out_tag,
    output logic [7:0]  o_out_age,
    output logic [7:0]  o_out_priority,
    output logic [4:0]  o_occupancy
);

    `include "stable_sorted_priority_queue_defines.svh"

    logic                      r_live;
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_strobe;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_out_valid;
    spq_pkg::t_entry           r_out;
    spq_pkg::t_entry           n_out;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    spq_pkg::t_cmd             w_cmd;
    spq_pkg::t_link            w_link [spq_pkg::DEPTH];
    spq_pkg::t_link            w_edge;
    logic [spq_pkg::DEPTH-1:0] w_valid_vec;
    logic [spq_pkg::CNT_W+4:0] w_count_ext;

    assign busy     = ~r_live;
    assign w_accept = start & ~busy;
    assign w_full   = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_cmd.ins         = w_accept & (i_kind == spq_pkg::KIND_INSERT) & ~w_full;
    assign w_cmd.rem         = w_accept & (i_kind == spq_pkg::KIND_REMOVE) & ~w_empty;
    assign w_cmd.entry.tag   = i_payload_tag;
    assign w_cmd.entry.age   = i_age;
    assign w_cmd.entry.prio  = i_priority_req;

    assign w_edge.valid = 1'b0;
    assign w_edge.lt    = 1'b0;
    assign w_edge.entry = '0;

    for (genvar gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
        spq_pkg::t_link w_left;
        spq_pkg::t_link w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_edge;
        end else begin : g_mid_l
            assign w_left = w_link[gi-1];
        end
        if (gi == spq_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_edge;
        end else begin : g_mid_r
            assign w_right = w_link[gi+1];
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[gi])
        );
        assign w_valid_vec[gi] = w_link[gi].valid;
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        n_out    = '0;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
            n_out   = w_link[0].entry;
        end else if (i_kind == spq_pkg::KIND_INSERT) begin
            n_status = spq_pkg::ST_FULL;
        end else begin
            n_status = spq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_count     <= '0;
            r_strobe    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_live      <= 1'b1;
            r_strobe    <= w_accept;
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= w_cmd.rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign w_count_ext    = (spq_pkg::CNT_W + 5)'(r_count);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_valid    = r_out_valid & r_strobe;
    assign o_out_tag      = r_out.tag;
    assign o_out_age      = r_out.age;
    assign o_out_priority = r_out.prio;
    assign o_occupancy    = w_count_ext[4:0];

    `SPQ_ASSERT_NEXT(a_strobe_follows, w_accept, o_strobe)
    `SPQ_ASSERT_NOW(a_valid_ok, o_out_valid, o_strobe && (o_status == spq_pkg::ST_OK))
    `SPQ_ASSERT_NOW(a_count_bits, r_live, $countones(w_valid_vec) == 32'(r_count))
    `SPQ_ASSERT_NEXT(a_full_holds, w_accept && w_full && (i_kind == spq_pkg::KIND_INSERT),
        $stable(r_count) && (o_status == spq_pkg::ST_FULL))

endmodule

FILE: rtl/spq_cell.sv
// one slot of the sorted chain: keeps, shifts in from a neighbor or takes the new word
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd  i_cmd,
    input  spq_pkg::t_link i_left,
    input  spq_pkg::t_link i_right,
    output spq_pkg::t_link o_link
);

    logic            r_valid;
    logic            n_valid;
    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_self_lt;

    assign w_self_lt = ~r_valid | (r_entry.prio < i_cmd.entry.prio);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_left.lt) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else if (w_self_lt) begin
                n_valid = 1'b1;
                n_entry = i_cmd.entry;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.valid = r_valid;
    assign o_link.lt    = w_self_lt;
    assign o_link.entry = r_entry;

endmodule

FILE: tb/sv/tb_stable_sorted_priority_queue.sv
// self-checking testbench for the stable sorted priority queue
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;
    import spq_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic        valid;
        logic [31:0] tag;
        logic [7:0]  age;
        logic [7:0]  prio;
        logic [4:0]  occupancy;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = KIND_INSERT;
    logic [31:0] i_payload_tag = '0;
    logic [7:0]  i_age = '0;
    logic [7:0]  i_priority_req = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic        o_out_valid;
    logic [31:0] o_out_tag;
    logic [7:0]  o_out_age;
    logic [7:0]  o_out_priority;
    logic [4:0]  o_occupancy;

    t_entry   sorted_entries[$];
    t_outcome pending_outcomes[$];
    int       fail_count = 0;
    int       idle_pct = 9;

    stable_sorted_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_payload_tag  (i_payload_tag),
        .i_age          (i_age),
        .i_priority_req (i_priority_req),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_valid    (o_out_valid),
        .o_out_tag      (o_out_tag),
        .o_out_age      (o_out_age),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_outcome apply_word(logic kind, logic [31:0] tag, logic [7:0] age,
                                            logic [7:0] prio);
        t_outcome res;
        t_entry   head;
        int       pos;
        res = '{status: ST_OK, valid: 1'b0, tag: '0, age: '0, prio: '0, occupancy: '0};
        if (kind == KIND_INSERT) begin
            if (sorted_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos].prio >= prio)
                    pos++;
                sorted_entries.insert(pos, '{tag: tag, age: age, prio: prio});
            end
        end else begin
            if (sorted_entries.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                head = sorted_entries.pop_front();
                res.valid = 1'b1;
                res.tag = head.tag;
                res.age = head.age;
                res.prio = head.prio;
            end
        end
        res.occupancy = 5'(sorted_entries.size());
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // predict on every accepted word, then check any result strobed at this edge
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (start && !busy)
                pending_outcomes.push_back(apply_word(i_kind, i_payload_tag, i_age,
                                                      i_priority_req));
            if (o_strobe) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result strobed with nothing outstanding");
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("out_valid", 32'(want.valid), 32'(o_out_valid));
                    check_field("out_tag", want.tag, o_out_tag);
                    check_field("out_age", 32'(want.age), 32'(o_out_age));
                    check_field("out_priority", 32'(want.prio), 32'(o_out_priority));
                    check_field("occupancy", 32'(want.occupancy), 32'(o_occupancy));
                end
            end
        end
    end

    task automatic send_word(logic kind, logic [31:0] tag, logic [7:0] age, logic [7:0] prio);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_payload_tag <= tag;
        i_age <= age;
        i_priority_req <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // removes on an empty queue, with payload fields at both extremes
    task automatic test_empty_remove();
        send_word(KIND_REMOVE, 32'h0, 8'h00, 8'h00);
        send_word(KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    endtask

    // fill with extreme and tied priorities, overflow once, then drain the head
    task automatic test_fill_and_overflow();
        logic [7:0] prio_set[16] = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h7F,
                                     8'h01, 8'hFE, 8'h80, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80};
        logic [31:0] tag;
        for (int k = 0; k < DEPTH; k++) begin
            tag = (k % 3 == 0) ? 32'h0 : (k % 3 == 1) ? 32'hFFFF_FFFF : $urandom;
            send_word(KIND_INSERT, tag, (k % 2 == 0) ? 8'hFF : 8'(k), prio_set[k]);
        end
        send_word(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        for (int k = 0; k < 4; k++)
            send_word(KIND_REMOVE, $urandom, 8'($urandom), 8'($urandom));
    endtask

    // mixed traffic that swings between filling, draining and balanced phases
    task automatic test_random_traffic(int n_words);
        int         insert_pct;
        logic       kind;
        logic [7:0] prio;
        insert_pct = 50;
        for (int k = 0; k < n_words; k++) begin
            if (k % 60 == 0)
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            idle_pct = (k >= 400 && k < 700) ? 0 : 9;
            kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            if ($urandom_range(3) == 0)
                prio = 8'($urandom_range(255));
            else
                prio = 8'($urandom_range(3)) * 8'h55;
            send_word(kind, $urandom, 8'($urandom), prio);
        end
        idle_pct = 9;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_remove();
        test_fill_and_overflow();
        test_random_traffic(1200);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[stable_sorted_priority_queue] OK");
        else
            $display("[stable_sorted_priority_queue] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[stable_sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
